>>> sv/float_quicksort_engine_defines.svh
// Assertion macros shared by the float quicksort engine files.
`ifndef FLOAT_QUICKSORT_ENGINE_DEFINES_SVH
`define FLOAT_QUICKSORT_ENGINE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FQS_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define FQS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

>>> sv/fqs_pkg.sv
// Package of the float quicksort engine: types, constants and the float compare.
package fqs_pkg;

    localparam int FQS_MAX_ITEMS = 64;
    localparam int FQS_VALUE_W   = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP_RD,
        ST_POP_GET,
        ST_PIV,
        ST_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FIN_RD,
        ST_FIN,
        ST_FIN_WR,
        ST_PUSH_R,
        ST_EM_RD,
        ST_EM_CAP,
        ST_EM_HOLD
    } fqs_state_t;

    // Single-precision a <= b; false when either side is NaN.
    function automatic logic fqs_float_le(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan) begin
            res = 1'b0;
        end else if (both_zero) begin
            res = 1'b1;
        end else if (a[31] != b[31]) begin
            res = a[31];
        end else if (a[31]) begin
            res = (a[30:0] >= b[30:0]);
        end else begin
            res = (a[30:0] <= b[30:0]);
        end
        return res;
    endfunction

endpackage

>>> sv/fqs_ram.sv
// Generic simple dual-port RAM with registered read.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one word per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/float_quicksort_engine.sv
// Float quicksort engine: collects a set, sorts it by Lomuto quicksort, streams it.
//
// Input channel s_*: one single-precision bit pattern per transfer; s_final_item
// closes the set. Values past MAX_ITEMS are dropped and flag the set.
// Output channel m_*: the set in ascending float order, m_end_of_run on the
// last value, m_overflowed on every value of a set that lost items.
// Loading accepts one value per cycle. After the final transfer the block sorts
// with one shared float comparator and one value RAM with a read and a write
// port: a partition pops a range, reads its last value as the pivot, compares
// each element and exchanges those that belong left of the boundary, then
// places the pivot and pushes the subranges. Emission reads each value into the
// output register and reads the next only after the current one is taken;
// a stall holds the current value in the output register and freezes the
// sort state. s_ready is low from the final transfer until the last value of
// the set is taken.
// Reset (synchronous, aresetn low) empties the set, the range stack and the
// overflow flag and returns to loading; RAM contents are not cleared.
module float_quicksort_engine
    import fqs_pkg::*;
#(
    parameter int MAX_ITEMS = FQS_MAX_ITEMS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [FQS_VALUE_W-1:0] s_sample_bits,
    input  logic                   s_final_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FQS_VALUE_W-1:0] m_sorted_bits,
    output logic                   m_end_of_run,
    output logic                   m_overflowed
);

`include "float_quicksort_engine_defines.svh"

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int STK_W = 2 * IDX_W;

    fqs_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0] k_reg, k_next, nx_reg, nx_next;
    logic [FQS_VALUE_W-1:0] piv_reg, piv_next, valk_reg, valk_next, tmp_reg, tmp_next;
    logic             mv_reg, mv_next, meor_reg, meor_next;
    logic [FQS_VALUE_W-1:0] mdat_reg, mdat_next;

    logic                   v_we;
    logic [IDX_W-1:0]       v_waddr, v_raddr;
    logic [FQS_VALUE_W-1:0] v_wdata, v_rdata;
    logic                   s_we;
    logic [IDX_W-1:0]       s_waddr, s_raddr;
    logic [STK_W-1:0]       s_wdata, s_rdata;

    logic             full;
    logic [CNT_W-1:0] cnt_after;
    logic [IDX_W-1:0] k_inc, nx_inc;
    logic             right_push;
    logic             emit_last;

    fqs_ram #(.WIDTH(FQS_VALUE_W), .DEPTH(MAX_ITEMS)) u_value_ram (
        .aclk (aclk), .we (v_we), .waddr (v_waddr), .wdata (v_wdata),
        .raddr (v_raddr), .rdata (v_rdata)
    );

    fqs_ram #(.WIDTH(STK_W), .DEPTH(MAX_ITEMS)) u_stack_ram (
        .aclk (aclk), .we (s_we), .waddr (s_waddr), .wdata (s_wdata),
        .raddr (s_raddr), .rdata (s_rdata)
    );

    assign full       = (count_reg == CNT_W'(MAX_ITEMS));
    assign cnt_after  = full ? count_reg : count_reg + CNT_W'(1);
    assign k_inc      = k_reg + IDX_W'(1);
    assign nx_inc     = nx_reg + IDX_W'(1);
    assign right_push = ({1'b0, nx_reg} + (IDX_W+1)'(1)) < {1'b0, hi_reg};
    assign emit_last  = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    assign s_ready       = (state_reg == ST_LOAD);
    assign m_valid       = mv_reg;
    assign m_sorted_bits = mdat_reg;
    assign m_end_of_run  = meor_reg;
    assign m_overflowed  = ovf_reg;

    // Hold state; clear control on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            sp_reg    <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sp_reg    <= sp_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
        end
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        k_reg    <= k_next;
        nx_reg   <= nx_next;
        piv_reg  <= piv_next;
        valk_reg <= valk_next;
        tmp_reg  <= tmp_next;
        mdat_reg <= mdat_next;
        meor_reg <= meor_next;
    end

    // Sequence load, partition, stack and emission steps.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sp_next    = sp_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        nx_next    = nx_reg;
        piv_next   = piv_reg;
        valk_next  = valk_reg;
        tmp_next   = tmp_reg;
        mv_next    = mv_reg;
        mdat_next  = mdat_reg;
        meor_next  = meor_reg;
        v_we       = 1'b0;
        v_waddr    = k_reg;
        v_wdata    = tmp_reg;
        v_raddr    = k_reg;
        s_we       = 1'b0;
        s_waddr    = sp_reg[IDX_W-1:0];
        s_wdata    = {nx_reg, lo_reg};
        s_raddr    = sp_reg[IDX_W-1:0] - IDX_W'(1);
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    v_waddr = count_reg[IDX_W-1:0];
                    v_wdata = s_sample_bits;
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        v_we = 1'b1;
                    end
                    count_next = cnt_after;
                    k_next     = '0;
                    if (s_final_item) begin
                        if (cnt_after >= CNT_W'(2)) begin
                            s_we       = 1'b1;
                            s_waddr    = '0;
                            s_wdata    = {IDX_W'(cnt_after - CNT_W'(1)), IDX_W'(0)};
                            sp_next    = CNT_W'(1);
                            state_next = ST_POP_RD;
                        end else begin
                            state_next = ST_EM_RD;
                        end
                    end
                end
            end
            ST_POP_RD: begin
                sp_next    = sp_reg - CNT_W'(1);
                state_next = ST_POP_GET;
            end
            ST_POP_GET: begin
                lo_next    = s_rdata[IDX_W-1:0];
                hi_next    = s_rdata[STK_W-1:IDX_W];
                v_raddr    = s_rdata[STK_W-1:IDX_W];
                state_next = ST_PIV;
            end
            ST_PIV: begin
                piv_next   = v_rdata;
                k_next     = lo_reg;
                nx_next    = lo_reg;
                v_raddr    = lo_reg;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                valk_next = v_rdata;
                if (fqs_float_le(v_rdata, piv_reg) && (nx_reg != k_reg)) begin
                    v_raddr    = nx_reg;
                    state_next = ST_SWAP_RD;
                end else begin
                    if (fqs_float_le(v_rdata, piv_reg)) begin
                        nx_next = nx_inc;
                    end
                    k_next  = k_inc;
                    v_raddr = k_inc;
                    if (k_inc == hi_reg) begin
                        state_next = ST_FIN_RD;
                    end
                end
            end
            ST_SWAP_RD: begin
                tmp_next   = v_rdata;
                v_we       = 1'b1;
                v_waddr    = nx_reg;
                v_wdata    = valk_reg;
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR: begin
                v_we    = 1'b1;
                v_waddr = k_reg;
                v_wdata = tmp_reg;
                nx_next = nx_inc;
                k_next  = k_inc;
                v_raddr = k_inc;
                if (k_inc == hi_reg) begin
                    state_next = ST_FIN_RD;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_FIN_RD: begin
                v_raddr    = nx_reg;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                tmp_next   = v_rdata;
                v_we       = 1'b1;
                v_waddr    = nx_reg;
                v_wdata    = piv_reg;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                v_we    = 1'b1;
                v_waddr = hi_reg;
                v_wdata = tmp_reg;
                // Push the left subrange when it holds two or more values.
                if (nx_reg > lo_reg) begin
                    if ((nx_reg - IDX_W'(1)) > lo_reg) begin
                        s_we    = 1'b1;
                        s_wdata = {nx_reg - IDX_W'(1), lo_reg};
                        sp_next = sp_reg + CNT_W'(1);
                    end
                end
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                if (right_push) begin
                    s_we    = 1'b1;
                    s_wdata = {hi_reg, nx_inc};
                    sp_next = sp_reg + CNT_W'(1);
                    state_next = ST_POP_RD;
                end else if (sp_reg != '0) begin
                    state_next = ST_POP_RD;
                end else begin
                    k_next     = '0;
                    state_next = ST_EM_RD;
                end
            end
            ST_EM_RD: begin
                v_raddr    = k_reg;
                state_next = ST_EM_CAP;
            end
            ST_EM_CAP: begin
                mdat_next  = v_rdata;
                meor_next  = emit_last;
                mv_next    = 1'b1;
                state_next = ST_EM_HOLD;
            end
            ST_EM_HOLD: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (emit_last) begin
                        count_next = '0;
                        sp_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_inc;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `FQS_ASSERT_NOW(a_no_load_while_out, aclk, aresetn, s_ready, !m_valid)
    `FQS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `FQS_ASSERT_NOW(a_stack_bound, aclk, aresetn, 1'b1, sp_reg <= CNT_W'(MAX_ITEMS / 2))
    `FQS_ASSERT_NEXT(a_run_end_reload, aclk, aresetn,
        m_valid && m_ready && m_end_of_run, s_ready && (count_reg == '0))

endmodule
